// ----- design/multi_polygon_fence_check_assert.svh -----
// assertion macros used by the checker file of the fence check block
// depends on nothing; the user supplies clock, active-low reset and expressions
`ifndef MULTI_POLYGON_FENCE_CHECK_ASSERT_SVH
`define MULTI_POLYGON_FENCE_CHECK_ASSERT_SVH

// same-cycle implication, skipped while reset is low
`define MPFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpfc checker: property failed");

// next-cycle implication, skipped while reset is low
`define MPFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpfc checker: property failed");

`endif

// ----- design/mpfc_pkg.sv -----
// shared constants, codes and types of the multi polygon fence check block
// depends on nothing
package mpfc_pkg;

    localparam int NUM_FENCES   = 8;
    localparam int MAX_VERTICES = 32;
    localparam int COORD_W      = 24;
    localparam int MIN_VERTS    = 3;

    localparam int TABLE_DEPTH = NUM_FENCES * MAX_VERTICES;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FENCE_W     = (NUM_FENCES > 1) ? $clog2(NUM_FENCES) : 1;
    localparam int VIDX_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    // fixed payload field widths
    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int INDEX_W    = 5;
    localparam int COUNT_IN_W = 6;
    localparam int TAG_W      = 16;
    localparam int MASK_W     = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_VERTEX = 2'd0,
        FUNC_SET_HEADER   = 2'd1,
        FUNC_CHECK        = 2'd2,
        FUNC_CLEAR_ALL    = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    typedef struct packed {
        logic done;
        logic hit;
    } t_edge_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FENCE,
        S_PREV,
        S_LOAD,
        S_EDGE,
        S_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL_A,
        E_MUL_B,
        E_CMP
    } t_edge_state;

endpackage

// ----- design/mpfc_if.sv -----
// valid/ready stream interfaces for the fence check input and result channels
// depends on mpfc_pkg
interface mpfc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [mpfc_pkg::FUNC_W-1:0]            func;
    logic [mpfc_pkg::SLOT_W-1:0]            fence_slot;
    logic [mpfc_pkg::INDEX_W-1:0]           vertex_index;
    logic signed [mpfc_pkg::COORD_W-1:0]    coord_x;
    logic signed [mpfc_pkg::COORD_W-1:0]    coord_y;
    logic [mpfc_pkg::COUNT_IN_W-1:0]        vertex_count;
    logic                                   enable_flag;
    logic [mpfc_pkg::TAG_W-1:0]             target_tag;

    modport source (
        output valid, func, fence_slot, vertex_index, coord_x, coord_y,
               vertex_count, enable_flag, target_tag,
        input  ready
    );
    modport sink (
        input  valid, func, fence_slot, vertex_index, coord_x, coord_y,
               vertex_count, enable_flag, target_tag,
        output ready
    );
endinterface

interface mpfc_out_if;
    logic                           valid;
    logic                           ready;
    logic [mpfc_pkg::MASK_W-1:0]    hit_mask;
    logic [mpfc_pkg::TAG_W-1:0]     tag_out;

    modport source (
        output valid, hit_mask, tag_out,
        input  ready
    );
    modport sink (
        input  valid, hit_mask, tag_out,
        output ready
    );
endinterface

// ----- design/mpfc_vertex_ram.sv -----
// vertex store: one write port, one registered read port
// depends on mpfc_pkg
module mpfc_vertex_ram (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [mpfc_pkg::ADDR_W-1:0] i_wr_addr,
    input  mpfc_pkg::t_vertex           i_wr_data,
    input  logic                        i_rd_en,
    input  logic [mpfc_pkg::ADDR_W-1:0] i_rd_addr,
    output mpfc_pkg::t_vertex           o_rd_data
);

    mpfc_pkg::t_vertex r_mem [mpfc_pkg::TABLE_DEPTH];
    mpfc_pkg::t_vertex r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/mpfc_edge_unit.sv -----
// shared edge crossing unit: one multiplier used twice per edge, then a compare
// depends on mpfc_pkg
module mpfc_edge_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  mpfc_pkg::t_vertex      i_point,
    input  mpfc_pkg::t_vertex      i_prev,
    input  mpfc_pkg::t_vertex      i_cur,
    output mpfc_pkg::t_edge_stat   o_stat
);

    localparam int DW = mpfc_pkg::DIFF_W;
    localparam int PW = mpfc_pkg::PROD_W;

    mpfc_pkg::t_edge_state r_state;
    mpfc_pkg::t_edge_state n_state;

    logic signed [mpfc_pkg::COORD_W-1:0] w_px, w_py, w_xi, w_yi, w_xj, w_yj;
    logic signed [DW-1:0] w_a, w_c, w_dy, w_ey;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d;
    logic signed [DW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_cross;

    assign w_px = i_point.x;
    assign w_py = i_point.y;
    assign w_xi = i_cur.x;
    assign w_yi = i_cur.y;
    assign w_xj = i_prev.x;
    assign w_yj = i_prev.y;

    // edge differences, widened by one bit
    assign w_a  = DW'(w_px) - DW'(w_xi);
    assign w_c  = DW'(w_xj) - DW'(w_xi);
    assign w_dy = DW'(w_yj) - DW'(w_yi);
    assign w_ey = DW'(w_py) - DW'(w_yi);

    // shared multiplier: (px-xi)*|dy| first, then (xj-xi)*ey with the sign of dy folded in
    assign w_ma   = (r_state == mpfc_pkg::E_MUL_A) ? r_a : r_c;
    assign w_mb   = (r_state == mpfc_pkg::E_MUL_A) ? r_b : r_d;
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpfc_pkg::E_IDLE:  if (i_start) n_state = mpfc_pkg::E_MUL_A;
            mpfc_pkg::E_MUL_A: n_state = mpfc_pkg::E_MUL_B;
            mpfc_pkg::E_MUL_B: n_state = mpfc_pkg::E_CMP;
            mpfc_pkg::E_CMP:   n_state = mpfc_pkg::E_IDLE;
            default:           n_state = mpfc_pkg::E_IDLE;
        endcase
    end

    // status outputs
    always_comb begin
        o_stat.done = 1'b0;
        o_stat.hit  = 1'b0;
        unique case (r_state)
            mpfc_pkg::E_CMP: begin
                o_stat.done = 1'b1;
                o_stat.hit  = r_cross && (r_p1 < r_p2);
            end
            default: begin
                o_stat.done = 1'b0;
                o_stat.hit  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfc_pkg::E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // operand capture with the sign of dy folded in, then the two products
    always_ff @(posedge i_clk) begin
        case (r_state)
            mpfc_pkg::E_IDLE: begin
                if (i_start) begin
                    r_cross <= (w_yi > w_py) != (w_yj > w_py);
                    r_a     <= w_a;
                    r_c     <= w_c;
                    r_b     <= w_dy[DW-1] ? -w_dy : w_dy;
                    r_d     <= w_dy[DW-1] ? -w_ey : w_ey;
                end
            end
            mpfc_pkg::E_MUL_A: r_p1 <= w_prod;
            mpfc_pkg::E_MUL_B: r_p2 <= w_prod;
            default: ;
        endcase
    end

endmodule

// ----- design/multi_polygon_fence_check.sv -----
// Multi polygon fence check. Holds 8 fences of up to 32 vertices and runs an even-odd
// ray-casting test of a point against every enabled fence with at least 3 vertices,
// returning one hit mask and the passed-through tag per check. Vertex writes, header
// writes and clear-all return nothing. A check walks the fences in turn, skipping
// inactive ones, and may wait for the result register to drain; the input is not
// ready until the check is done. Each edge is one vertex store read and then the
// shared edge unit, whose single multiplier forms the two cross products one after
// the other before the compare.
// Depends on mpfc_pkg, mpfc_if, mpfc_vertex_ram and mpfc_edge_unit.
module multi_polygon_fence_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpfc_in_if.sink     i_in,
    mpfc_out_if.source  o_out
);

    localparam int AW = mpfc_pkg::ADDR_W;
    localparam int FW = mpfc_pkg::FENCE_W;
    localparam int VW = mpfc_pkg::VIDX_W;
    localparam int CW = mpfc_pkg::CNT_W;
    localparam int MW = mpfc_pkg::MASK_W;

    mpfc_pkg::t_seq_state r_state;
    mpfc_pkg::t_seq_state n_state;

    // fence headers
    logic [CW-1:0]                  r_count [mpfc_pkg::NUM_FENCES];
    logic [mpfc_pkg::NUM_FENCES-1:0] r_enable;

    // check context
    logic [FW-1:0]              r_fence;
    logic [VW-1:0]              r_vidx;
    logic                       r_inside;
    logic [MW-1:0]              r_mask;
    mpfc_pkg::t_vertex          r_point;
    logic [mpfc_pkg::TAG_W-1:0] r_tag;
    mpfc_pkg::t_vertex          r_prev;
    mpfc_pkg::t_vertex          r_cur;

    // result register
    logic                       r_out_valid;
    logic [MW-1:0]              r_out_mask;
    logic [mpfc_pkg::TAG_W-1:0] r_out_tag;

    mpfc_pkg::t_func      w_func;
    logic                 w_in_xfer;
    logic                 w_slot_ok;
    logic                 w_vidx_ok;
    logic [FW-1:0]        w_slot;
    logic [CW-1:0]        w_cnt_sat;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    mpfc_pkg::t_vertex    w_wr_data;
    logic                 w_rd_en;
    logic [VW-1:0]        w_rd_idx;
    logic [AW-1:0]        w_rd_addr;
    mpfc_pkg::t_vertex    w_rd_data;
    logic                 w_edge_start;
    mpfc_pkg::t_edge_stat w_edge;
    logic                 w_in_ready;
    logic                 w_active;
    logic                 w_last_fence;
    logic                 w_last_edge;
    logic [VW-1:0]        w_last_idx;
    logic                 w_fence_hit;
    logic                 w_out_free;

    // input decode
    assign w_func     = mpfc_pkg::t_func'(i_in.func);
    assign w_in_xfer  = i_in.valid && w_in_ready;
    assign w_slot_ok  = int'(i_in.fence_slot) < mpfc_pkg::NUM_FENCES;
    assign w_vidx_ok  = int'(i_in.vertex_index) < mpfc_pkg::MAX_VERTICES;
    assign w_slot     = FW'(i_in.fence_slot);
    assign w_cnt_sat  = (int'(i_in.vertex_count) > mpfc_pkg::MAX_VERTICES)
                        ? CW'(mpfc_pkg::MAX_VERTICES) : CW'(i_in.vertex_count);
    assign w_wr_en    = w_in_xfer && (w_func == mpfc_pkg::FUNC_WRITE_VERTEX)
                        && w_slot_ok && w_vidx_ok;
    assign w_wr_addr  = AW'(int'(i_in.fence_slot) * mpfc_pkg::MAX_VERTICES
                        + int'(i_in.vertex_index));
    assign w_wr_data.x = i_in.coord_x;
    assign w_wr_data.y = i_in.coord_y;

    // current fence status
    assign w_active     = r_enable[r_fence] && (r_count[r_fence] >= CW'(mpfc_pkg::MIN_VERTS));
    assign w_last_fence = int'(r_fence) == mpfc_pkg::NUM_FENCES - 1;
    assign w_last_idx   = VW'(r_count[r_fence] - CW'(1));
    assign w_last_edge  = r_vidx == w_last_idx;
    assign w_fence_hit  = r_inside ^ w_edge.hit;
    assign w_rd_addr    = AW'(int'(r_fence) * mpfc_pkg::MAX_VERTICES + int'(w_rd_idx));
    assign w_out_free   = !r_out_valid || o_out.ready;

    mpfc_vertex_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mpfc_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_edge_start),
        .i_point (r_point),
        .i_prev  (r_prev),
        .i_cur   (w_rd_data),
        .o_stat  (w_edge)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpfc_pkg::S_IDLE: begin
                if (w_in_xfer && (w_func == mpfc_pkg::FUNC_CHECK)) n_state = mpfc_pkg::S_FENCE;
            end
            mpfc_pkg::S_FENCE: begin
                if (w_active) n_state = mpfc_pkg::S_PREV;
                else if (w_last_fence) n_state = mpfc_pkg::S_OUT;
            end
            mpfc_pkg::S_PREV: n_state = mpfc_pkg::S_LOAD;
            mpfc_pkg::S_LOAD: n_state = mpfc_pkg::S_EDGE;
            mpfc_pkg::S_EDGE: begin
                if (w_edge.done) begin
                    if (!w_last_edge) n_state = mpfc_pkg::S_LOAD;
                    else if (w_last_fence) n_state = mpfc_pkg::S_OUT;
                    else n_state = mpfc_pkg::S_FENCE;
                end
            end
            mpfc_pkg::S_OUT: begin
                if (w_out_free) n_state = mpfc_pkg::S_IDLE;
            end
            default: n_state = mpfc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: ready, vertex reads, edge start
    always_comb begin
        w_in_ready   = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_idx     = r_vidx;
        w_edge_start = 1'b0;
        unique case (r_state)
            mpfc_pkg::S_IDLE: w_in_ready = 1'b1;
            mpfc_pkg::S_FENCE: begin
                w_rd_en  = w_active;
                w_rd_idx = w_last_idx;
            end
            mpfc_pkg::S_PREV: w_rd_en = 1'b1;
            mpfc_pkg::S_LOAD: w_edge_start = 1'b1;
            mpfc_pkg::S_EDGE: begin
                w_rd_en  = w_edge.done && !w_last_edge;
                w_rd_idx = r_vidx + VW'(1);
            end
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // fence headers: set one, or clear all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '{default: '0};
            r_enable <= '0;
        end else if (w_in_xfer) begin
            case (w_func)
                mpfc_pkg::FUNC_SET_HEADER: begin
                    if (w_slot_ok) begin
                        r_count[w_slot]  <= w_cnt_sat;
                        r_enable[w_slot] <= i_in.enable_flag;
                    end
                end
                mpfc_pkg::FUNC_CLEAR_ALL: begin
                    r_count  <= '{default: '0};
                    r_enable <= '0;
                end
                default: ;
            endcase
        end
    end

    // loop counters, parity and mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fence  <= '0;
            r_vidx   <= '0;
            r_inside <= 1'b0;
            r_mask   <= '0;
        end else begin
            case (r_state)
                mpfc_pkg::S_IDLE: begin
                    if (w_in_xfer && (w_func == mpfc_pkg::FUNC_CHECK)) begin
                        r_fence <= '0;
                        r_mask  <= '0;
                    end
                end
                mpfc_pkg::S_FENCE: begin
                    if (w_active) begin
                        r_vidx   <= '0;
                        r_inside <= 1'b0;
                    end else if (!w_last_fence) begin
                        r_fence <= r_fence + FW'(1);
                    end
                end
                mpfc_pkg::S_EDGE: begin
                    if (w_edge.done) begin
                        r_inside <= w_fence_hit;
                        if (w_last_edge) begin
                            r_mask <= r_mask | (MW'(w_fence_hit) << r_fence);
                            if (!w_last_fence) r_fence <= r_fence + FW'(1);
                        end else begin
                            r_vidx <= r_vidx + VW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // check payload and edge end points
    always_ff @(posedge i_clk) begin
        case (r_state)
            mpfc_pkg::S_IDLE: begin
                if (w_in_xfer && (w_func == mpfc_pkg::FUNC_CHECK)) begin
                    r_point.x <= i_in.coord_x;
                    r_point.y <= i_in.coord_y;
                    r_tag     <= i_in.target_tag;
                end
            end
            mpfc_pkg::S_PREV: r_prev <= w_rd_data;
            mpfc_pkg::S_LOAD: r_cur  <= w_rd_data;
            mpfc_pkg::S_EDGE: begin
                if (w_edge.done) r_prev <= r_cur;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == mpfc_pkg::S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mpfc_pkg::S_OUT) && w_out_free) begin
            r_out_mask <= r_mask;
            r_out_tag  <= r_tag;
        end
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.hit_mask = r_out_mask;
    assign o_out.tag_out  = r_out_tag;

endmodule

// ----- design/mpfc_checker.sv -----
// port-level checker for the fence check block, attached by bind
// depends on mpfc_pkg, multi_polygon_fence_check_assert.svh and the top level
`include "multi_polygon_fence_check_assert.svh"

module mpfc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [mpfc_pkg::FUNC_W-1:0]   i_in_func,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mpfc_pkg::MASK_W-1:0]   i_out_hit_mask,
    input logic [mpfc_pkg::TAG_W-1:0]    i_out_tag
);

    logic w_stall;
    logic w_chk_xfer;

    // result offered but not taken, and a check transfer on the input
    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_chk_xfer = i_in_valid && i_in_ready && (i_in_func == mpfc_pkg::FUNC_CHECK);

    // a stalled result stays offered
    `MPFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid)

    // a stalled result keeps its payload
    `MPFC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable({i_out_hit_mask, i_out_tag}))

    // a check transfer makes the block busy on the next cycle
    `MPFC_ASSERT_NXT(a_check_busy, i_clk, i_rst_n, w_chk_xfer, !i_in_ready)

    // a new result only appears at the end of a check, while the input was closed
    `MPFC_ASSERT_IMP(a_result_from_check, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind multi_polygon_fence_check mpfc_checker u_mpfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_hit_mask (o_out.hit_mask),
    .i_out_tag      (o_out.tag_out)
);
